/* design/pip_pkg.sv */
// Shared constants and types for the point-in-polygon test block.
// Used by the edge unit, the top level and the checker; depends on nothing.
`default_nettype none

package pip_pkg;

	localparam int MAX_VERTICES = 8;
	localparam int COORD_WIDTH  = 16;
	localparam int CFG_W        = 4;
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int DIFF_W       = COORD_WIDTH + 1;
	localparam int PROD_W       = 2 * DIFF_W;
	localparam int VERT_W       = 2 * COORD_WIDTH;

	localparam logic [CFG_W-1:0] VERTEX_COUNT_RESET = CFG_W'(4);

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_TEST  = 1'b1;

	// Control from the sequencer to the shared edge unit.
	typedef struct packed {
		logic mul_en;   // register a new product this cycle
		logic sel_rhs;  // 0: (px - x1) * dy, 1: (x2 - x1) * (py - y1)
	} edge_ctrl_t;

endpackage

`default_nettype wire

/* design/pip_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the polygon corners for the top level.
`default_nettype none

module pip_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* design/pip_edge_unit.sv */
// Shared edge unit: one subtract pair, one multiplier and one wide compare.
// Depends on pip_pkg; driven by the sequencer in the top level.
`default_nettype none

module pip_edge_unit
	import pip_pkg::*;
(
	input  wire logic                          clk,
	input  wire edge_ctrl_t                    ctrl,
	input  wire logic signed [COORD_WIDTH-1:0] px,
	input  wire logic signed [COORD_WIDTH-1:0] py,
	input  wire logic signed [COORD_WIDTH-1:0] x1,
	input  wire logic signed [COORD_WIDTH-1:0] y1,
	input  wire logic signed [COORD_WIDTH-1:0] x2,
	input  wire logic signed [COORD_WIDTH-1:0] y2,
	output logic                               hit
);

	logic signed [DIFF_W-1:0] op_a;
	logic signed [DIFF_W-1:0] op_b;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PROD_W-1:0] lhs_q;
	logic                     straddle_q;
	logic                     dy_pos_q;
	logic                     left;

	always_comb begin
		if (ctrl.sel_rhs) begin
			op_a = DIFF_W'(x2) - DIFF_W'(x1);
			op_b = DIFF_W'(py) - DIFF_W'(y1);
		end else begin
			op_a = DIFF_W'(px) - DIFF_W'(x1);
			op_b = DIFF_W'(y2) - DIFF_W'(y1);
		end
	end

	// The first product of an edge moves into lhs_q while the second is formed,
	// so the comparison runs in the cycle after the second product.
	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s1 <= op_a * op_b;
			if (ctrl.sel_rhs) begin
				lhs_q <= prod_s1;
			end else begin
				straddle_q <= (y1 > py) != (y2 > py);
				dy_pos_q   <= (y2 > y1);
			end
		end
	end

	// A straddling edge never has dy equal to zero.
	assign left = dy_pos_q ? (lhs_q < prod_s1) : (prod_s1 < lhs_q);
	assign hit  = straddle_q & left;

endmodule

`default_nettype wire

/* design/point_in_polygon_test.sv */
// Point-in-polygon test by crossing parity. A vertex write leaves the block ready
// again in the next cycle. A test of n vertices (n above zero) runs from acceptance
// to its result word through PRIME and PREV, which prime the corner memory, then A
// and B for each edge on the shared multiplier, LAST for the final compare and DONE
// to hand the word over. With no vertices in use it goes straight to DONE. The block
// takes no new word while a test runs, and DONE waits while an earlier result word
// is still held. Reset clears the sequencer and sets vertex_count to 4; the corner
// memory is not cleared.
`default_nettype none

module point_in_polygon_test
	import pip_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [CFG_W-1:0]              cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          command,
	input  wire logic [2:0]                    vertex_index,
	input  wire logic signed [COORD_WIDTH-1:0] vertex_x,
	input  wire logic signed [COORD_WIDTH-1:0] vertex_y,
	input  wire logic signed [COORD_WIDTH-1:0] point_x,
	input  wire logic signed [COORD_WIDTH-1:0] point_y,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               inside_res
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PRIME = 3'd1;
	localparam logic [2:0] ST_PREV  = 3'd2;
	localparam logic [2:0] ST_A     = 3'd3;
	localparam logic [2:0] ST_B     = 3'd4;
	localparam logic [2:0] ST_LAST  = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]                    state_q;
	logic [CFG_W-1:0]              vertex_count_q;
	logic [CNT_W-1:0]              n_eff;
	logic [CNT_W-1:0]              n_q;
	logic [CNT_W-1:0]              edge_q;
	logic [CNT_W-1:0]              edge_next;
	logic signed [COORD_WIDTH-1:0] px_q;
	logic signed [COORD_WIDTH-1:0] py_q;
	logic signed [COORD_WIDTH-1:0] prev_x_q;
	logic signed [COORD_WIDTH-1:0] prev_y_q;
	logic signed [COORD_WIDTH-1:0] cur_x;
	logic signed [COORD_WIDTH-1:0] cur_y;
	logic                          inside_q;
	logic                          pend_q;
	logic                          hit;
	logic                          in_acc;
	logic                          out_free;
	logic                          ram_we;
	logic [VIDX_W-1:0]             ram_raddr;
	logic [VERT_W-1:0]             ram_rdata;
	edge_ctrl_t                    ectrl;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid & in_ready;
	assign out_free  = ~out_valid | out_ready;
	assign edge_next = edge_q + 1'b1;

	// A count above the memory depth saturates.
	assign n_eff = (32'(vertex_count_q) > MAX_VERTICES) ?
		CNT_W'(MAX_VERTICES) : CNT_W'(vertex_count_q);

	assign ram_we = in_acc & (command == CMD_WRITE) &
		(32'(vertex_index) < MAX_VERTICES);

	always_comb begin
		case (state_q)
			ST_PRIME: ram_raddr = VIDX_W'(n_q - 1'b1);
			ST_B:     ram_raddr = VIDX_W'(edge_next);
			default:  ram_raddr = VIDX_W'(edge_q);
		endcase
	end

	assign cur_x = ram_rdata[VERT_W-1:COORD_WIDTH];
	assign cur_y = ram_rdata[COORD_WIDTH-1:0];

	always_comb begin
		ectrl.mul_en  = (state_q == ST_A) || (state_q == ST_B);
		ectrl.sel_rhs = (state_q == ST_B);
	end

	pip_ram #(
		.WIDTH(VERT_W),
		.DEPTH(MAX_VERTICES)
	) u_corner_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(VIDX_W'(vertex_index)),
		.wdata({vertex_x, vertex_y}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	pip_edge_unit u_edge (
		.clk (clk),
		.ctrl(ectrl),
		.px  (px_q),
		.py  (py_q),
		.x1  (cur_x),
		.y1  (cur_y),
		.x2  (prev_x_q),
		.y2  (prev_y_q),
		.hit (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VERTEX_COUNT_RESET;
		end else if (cfg_we) begin
			vertex_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
			pend_q    <= 1'b0;
			inside_q  <= 1'b0;
			edge_q    <= '0;
			n_q       <= '0;
		end else begin
			// In the hand-over state the result word is handled below.
			if (out_valid && out_ready && (state_q != ST_DONE)) begin
				out_valid <= 1'b0;
			end
			pend_q <= (state_q == ST_B);
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (command == CMD_TEST)) begin
						n_q      <= n_eff;
						edge_q   <= '0;
						inside_q <= 1'b0;
						state_q  <= (n_eff == '0) ? ST_DONE : ST_PRIME;
					end
				end
				ST_PRIME: begin
					state_q <= ST_PREV;
				end
				ST_PREV: begin
					state_q <= ST_A;
				end
				ST_A: begin
					if (pend_q && hit) begin
						inside_q <= ~inside_q;
					end
					state_q <= ST_B;
				end
				ST_B: begin
					edge_q  <= edge_next;
					state_q <= (edge_next == n_q) ? ST_LAST : ST_A;
				end
				ST_LAST: begin
					if (hit) begin
						inside_q <= ~inside_q;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: test point, previous corner and result word.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_q <= point_x;
			py_q <= point_y;
		end
		if (state_q == ST_PREV || state_q == ST_B) begin
			prev_x_q <= cur_x;
			prev_y_q <= cur_y;
		end
		if (state_q == ST_DONE && out_free) begin
			inside_res <= inside_q;
		end
	end

endmodule

`default_nettype wire

/* design/pip_checker.sv */
// Port-level checker for point_in_polygon_test, attached by a bind statement.
// Depends on pip_pkg and sees only the top level's ports.
`default_nettype none

module pip_checker
	import pip_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic command,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic inside_res
);

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(inside_res))
		else $error("result word changed or dropped while stalled");

	// A test occupies the block for at least the following cycle.
	a_test_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == CMD_TEST |=> !in_ready)
		else $error("block ready directly after accepting a test");

	// A vertex write never makes the block busy.
	a_write_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == CMD_WRITE |=> in_ready)
		else $error("block busy after a vertex write");

	// A new result word only appears at the end of a test.
	a_out_from_test: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result word appeared while no test was running");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (.*);

`default_nettype wire
